// File: hw/rtl/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, lane tables and types for the active contraction stress block.
// ----------------------------------------------------------------------------
package acs_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   // Field widths.
   localparam int GRAD_W   = 32;
   localparam int FIB_W    = 26;
   localparam int TENS_W   = 32;
   localparam int STRESS_W = 32;
   localparam int LANES    = 6;

   // Bus widths: nine gradient entries and three fibre components, padded to bytes.
   localparam int REQ_FIELDS_W = 9 * GRAD_W + 3 * FIB_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int FIB_BASE     = 9 * GRAD_W;
   localparam int RSP_DATA_W   = LANES * STRESS_W;

   // Internal widths, each sized to the largest magnitude it can carry.
   localparam int GP_W   = 2 * GRAD_W;        // gradient product
   localparam int NP_W   = GRAD_W + FIB_W;    // gradient times fibre
   localparam int CW     = 66;                // cofactor
   localparam int BW     = 66;                // left Cauchy-Green entry, scale 2^48
   localparam int NTW    = 60;                // deformed fibre, scale 2^48
   localparam int NTH_W  = NTW - 32;          // upper slice of the deformed fibre
   localparam int JW     = 100;               // volume ratio, scale 2^72
   localparam int NFW    = 122;               // fibre dyad before rounding
   localparam int NRW    = 74;                // fibre dyad after rounding
   localparam int MW     = 70;                // b - N
   localparam int MH_W   = MW - 32;
   localparam int PW     = 104;               // (b - N) * T0
   localparam int NUM_W  = 128;               // numerator magnitude
   localparam int DEN_W  = 96;                // positive volume ratio
   localparam int QUOT_W = 32;
   localparam int CMP_W  = 130;
   localparam int DIV_ST = QUOT_W + 1;        // overflow check plus one stage per bit

   localparam int ROUND_SHIFT = 48;
   localparam int NUM_SHIFT   = 24;

   typedef logic [1:0] idx_type;

   // Row and column of each stress lane: xx, yy, zz, xy, yz, xz.
   localparam idx_type ROW_IDX [LANES] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd0};
   localparam idx_type COL_IDX [LANES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

   localparam logic [STRESS_W-1:0] STRESS_MAX = {1'b0, {(STRESS_W-1){1'b1}}};
   localparam logic [STRESS_W-1:0] STRESS_MIN = {1'b1, {(STRESS_W-1){1'b0}}};

   typedef struct packed {
      logic              ovf;
      logic [QUOT_W-1:0] quot;
   } div_res_type;

endpackage

// File: hw/rtl/acs_div.sv
// ----------------------------------------------------------------------------
// acs_div
// Pipelined restoring divider for one stress lane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module acs_div (
   input  logic                        clock,
   input  logic [acs_pkg::DIV_ST-1:0]  en,
   input  logic [acs_pkg::NUM_W-1:0]   num_in,
   input  logic [acs_pkg::DEN_W-1:0]   den_in,
   output acs_pkg::div_res_type        res
);
   import acs_pkg::*;

   logic [NUM_W-1:0]  rem_ff  [DIV_ST];
   logic [DEN_W-1:0]  den_ff  [DIV_ST];
   logic [QUOT_W-1:0] quot_ff [DIV_ST];
   logic              ovf_ff  [DIV_ST];

   logic [CMP_W-1:0]  trial   [1:DIV_ST-1];
   logic              fits    [1:DIV_ST-1];

   // Stage s tries bit QUOT_W - s of the quotient.
   always_comb begin
      for (int s = 1; s < DIV_ST; s++) begin
         trial[s] = CMP_W'(den_ff[s-1]) << (QUOT_W - s);
         fits[s]  = CMP_W'(rem_ff[s-1]) >= trial[s];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0]  <= num_in;
         den_ff[0]  <= den_in;
         quot_ff[0] <= '0;
         // A quotient of 2^32 or more saturates whatever its sign.
         ovf_ff[0]  <= CMP_W'(num_in) >= (CMP_W'(den_in) << QUOT_W);
      end
      for (int s = 1; s < DIV_ST; s++) begin
         if (en[s]) begin
            rem_ff[s]  <= fits[s] ? NUM_W'(CMP_W'(rem_ff[s-1]) - trial[s]) : rem_ff[s-1];
            den_ff[s]  <= den_ff[s-1];
            quot_ff[s] <= quot_ff[s-1] | (fits[s] ? (QUOT_W'(1) << (QUOT_W - s)) : '0);
            ovf_ff[s]  <= ovf_ff[s-1];
         end
      end
   end

   assign res.ovf  = ovf_ff[DIV_ST-1];
   assign res.quot = quot_ff[DIV_ST-1];

endmodule

// File: hw/rtl/active_contraction_stress.sv
// ----------------------------------------------------------------------------
// active_contraction_stress
// Active contraction Cauchy stress (b - N) * T0 / J for one material point.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   req_     in         F (nine Q8.24 entries, row-major) and fibre n (three Q2.24)
//   rsp_     out        six Q16.16 stress components, bad volume flag in tuser
//   csr_     in         write-only active tension T0, Q16.16
//
// One transaction is accepted per cycle unless a full pipeline is held by the
// consumer; each result passes ten arithmetic stages, 33 divider stages (an
// overflow check and one stage per quotient bit) and the output register.
// Every stage holds its own valid bit; a stage loads whenever it, or any stage
// after it, is empty, so bubbles close up and input is taken while a finished
// result waits at the output.
// Reset clears the valid bits and the tension register; data registers are not
// reset.
//
module active_contraction_stress #(
   parameter int DATA_WIDTH = acs_pkg::DATA_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // grad_xx, grad_xy, grad_xz, grad_yx, grad_yy, grad_yz, grad_zx, grad_zy,
   // grad_zz, fiber_x, fiber_y, fiber_z, two zero bits
   input  logic [acs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // stress_xx, stress_yy, stress_zz, stress_xy, stress_yz, stress_xz
   output logic [acs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // bad_volume
   output logic                            rsp_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_wr_en,
   input  logic [acs_pkg::TENS_W-1:0]      csr_wr_data
);
   import acs_pkg::*;

   // Gradient entries are sign-extended from their low bits when the data path is
   // narrower than the field.
   localparam int GRAD_EXT = (DATA_WIDTH < GRAD_W) ? DATA_WIDTH : GRAD_W;

   localparam int ST_DIV0 = 10;
   localparam int ST_OUT  = ST_DIV0 + DIV_ST;
   localparam int NST     = ST_OUT + 1;

   localparam logic signed [NFW-1:0] N_HALF = NFW'(1) <<< (ROUND_SHIFT - 1);

   // ------------------------------------------------------------------ control
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;

   // A stage may load when the consumer is ready or some stage from it onwards
   // is empty; each enable is an independent reduction.
   always_comb begin
      for (int s = 0; s < NST; s++) begin
         en[s] = rsp_tready || (((~vld_ff) >> s) != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int s = 1; s < NST; s++) begin
            if (en[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NST-1];

   // Write the tension register only while idle; the block leaves it to the user.
   logic signed [TENS_W-1:0] tension_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tension_ff <= '0;
      end else if (csr_wr_en) begin
         tension_ff <= csr_wr_data;
      end
   end

   // ------------------------------------------------------ stage 0: capture
   logic signed [GRAD_W-1:0] f0_ff [3][3];
   logic signed [FIB_W-1:0]  n0_ff [3];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               f0_ff[i][j] <= GRAD_W'(signed'(req_tdata[(3*i+j)*GRAD_W +: GRAD_EXT]));
            end
            n0_ff[i] <= req_tdata[FIB_BASE + i*FIB_W +: FIB_W];
         end
      end
   end

   // ---------------------------------------------------- stage 1: products
   // Cofactor products for the determinant, the terms of F*F^T and of F*n.
   logic signed [GP_W-1:0]   cp1_ff [6];
   logic signed [GP_W-1:0]   bp1_ff [LANES][3];
   logic signed [NP_W-1:0]   np1_ff [3][3];
   logic signed [GRAD_W-1:0] fr1_ff [3];

   always_ff @(posedge clock) begin
      if (en[1]) begin
         cp1_ff[0] <= f0_ff[1][1] * f0_ff[2][2];
         cp1_ff[1] <= f0_ff[1][2] * f0_ff[2][1];
         cp1_ff[2] <= f0_ff[1][0] * f0_ff[2][2];
         cp1_ff[3] <= f0_ff[1][2] * f0_ff[2][0];
         cp1_ff[4] <= f0_ff[1][0] * f0_ff[2][1];
         cp1_ff[5] <= f0_ff[1][1] * f0_ff[2][0];
         for (int k = 0; k < LANES; k++) begin
            for (int t = 0; t < 3; t++) begin
               bp1_ff[k][t] <= f0_ff[ROW_IDX[k]][t] * f0_ff[COL_IDX[k]][t];
            end
         end
         for (int i = 0; i < 3; i++) begin
            for (int t = 0; t < 3; t++) begin
               np1_ff[i][t] <= f0_ff[i][t] * n0_ff[t];
            end
            fr1_ff[i] <= f0_ff[0][i];
         end
      end
   end

   // -------------------------------------------------------- stage 2: sums
   logic signed [CW-1:0]     c2_ff  [3];
   logic signed [BW-1:0]     b2_ff  [LANES];
   logic signed [NTW-1:0]    nt2_ff [3];
   logic signed [GRAD_W-1:0] fr2_ff [3];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            c2_ff[i]  <= CW'(cp1_ff[2*i]) - CW'(cp1_ff[2*i+1]);
            nt2_ff[i] <= NTW'(np1_ff[i][0]) + NTW'(np1_ff[i][1]) + NTW'(np1_ff[i][2]);
            fr2_ff[i] <= fr1_ff[i];
         end
         for (int k = 0; k < LANES; k++) begin
            b2_ff[k] <= BW'(bp1_ff[k][0]) + BW'(bp1_ff[k][1]) + BW'(bp1_ff[k][2]);
         end
      end
   end

   // ----------------------------------------- stage 3: split wide products
   // Cofactors and deformed fibre are cut at bit 32 so no product exceeds
   // about 32 by 32 bits.
   logic signed [GRAD_W+32:0]       jl3_ff [3];
   logic signed [CW-32+GRAD_W-1:0]  jh3_ff [3];
   logic        [63:0]              nll3_ff [LANES];
   logic signed [NTH_W+32:0]        nlh3_ff [LANES];
   logic signed [NTH_W+32:0]        nhl3_ff [LANES];
   logic signed [2*NTH_W-1:0]       nhh3_ff [LANES];
   logic signed [BW-1:0]            b3_ff   [LANES];

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int i = 0; i < 3; i++) begin
            jl3_ff[i] <= signed'({1'b0, c2_ff[i][31:0]}) * fr2_ff[i];
            jh3_ff[i] <= signed'(c2_ff[i][CW-1:32]) * fr2_ff[i];
         end
         for (int k = 0; k < LANES; k++) begin
            nll3_ff[k] <= nt2_ff[ROW_IDX[k]][31:0] * nt2_ff[COL_IDX[k]][31:0];
            nlh3_ff[k] <= signed'({1'b0, nt2_ff[ROW_IDX[k]][31:0]})
                          * signed'(nt2_ff[COL_IDX[k]][NTW-1:32]);
            nhl3_ff[k] <= signed'(nt2_ff[ROW_IDX[k]][NTW-1:32])
                          * signed'({1'b0, nt2_ff[COL_IDX[k]][31:0]});
            nhh3_ff[k] <= signed'(nt2_ff[ROW_IDX[k]][NTW-1:32])
                          * signed'(nt2_ff[COL_IDX[k]][NTW-1:32]);
            b3_ff[k]   <= b2_ff[k];
         end
      end
   end

   // ------------------------------------------- stage 4: rejoin the halves
   logic signed [JW-1:0]  jt4_ff [3];
   logic signed [NFW-1:0] nf4_ff [LANES];
   logic signed [BW-1:0]  b4_ff  [LANES];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int i = 0; i < 3; i++) begin
            jt4_ff[i] <= (JW'(jh3_ff[i]) <<< 32) + JW'(jl3_ff[i]);
         end
         for (int k = 0; k < LANES; k++) begin
            nf4_ff[k] <= (NFW'(nhh3_ff[k]) <<< 64)
                         + ((NFW'(nlh3_ff[k]) + NFW'(nhl3_ff[k])) <<< 32)
                         + signed'(NFW'(nll3_ff[k]));
            b4_ff[k]  <= b3_ff[k];
         end
      end
   end

   // ------------------------------ stage 5: determinant and dyad rounding
   logic signed [JW-1:0]  j5_ff;
   logic signed [NRW-1:0] nr5_ff [LANES];
   logic signed [BW-1:0]  b5_ff  [LANES];
   logic signed [NFW-1:0] nf_half [LANES];

   // Round half up: add one half, then shift with floor.
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         nf_half[k] = (nf4_ff[k] + N_HALF) >>> ROUND_SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         j5_ff <= jt4_ff[0] - jt4_ff[1] + jt4_ff[2];
         for (int k = 0; k < LANES; k++) begin
            nr5_ff[k] <= NRW'(nf_half[k]);
            b5_ff[k]  <= b4_ff[k];
         end
      end
   end

   // ------------------------------------- stage 6: b - N and volume check
   logic signed [MW-1:0]  m6_ff [LANES];
   logic signed [JW-1:0]  j6_ff;
   logic                  bad6_ff;
   logic signed [NRW-1:0] m_diff [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         m_diff[k] = NRW'(b5_ff[k]) - nr5_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int k = 0; k < LANES; k++) begin
            m6_ff[k] <= MW'(m_diff[k]);
         end
         j6_ff   <= j5_ff;
         bad6_ff <= (j5_ff <= 0);
      end
   end

   // ------------------------------------------- stage 7: times the tension
   logic signed [TENS_W+32:0]     ml7_ff [LANES];
   logic signed [MH_W+TENS_W-1:0] mh7_ff [LANES];
   logic signed [JW-1:0]          j7_ff;
   logic                          bad7_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int k = 0; k < LANES; k++) begin
            ml7_ff[k] <= signed'({1'b0, m6_ff[k][31:0]}) * tension_ff;
            mh7_ff[k] <= signed'(m6_ff[k][MW-1:32]) * tension_ff;
         end
         j7_ff   <= j6_ff;
         bad7_ff <= bad6_ff;
      end
   end

   // ------------------------------------------------- stage 8: rejoin
   logic signed [PW-1:0] pr8_ff [LANES];
   logic signed [JW-1:0] j8_ff;
   logic                 bad8_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int k = 0; k < LANES; k++) begin
            pr8_ff[k] <= (PW'(mh7_ff[k]) <<< 32) + PW'(ml7_ff[k]);
         end
         j8_ff   <= j7_ff;
         bad8_ff <= bad7_ff;
      end
   end

   // ------------------------------------------ stage 9: sign and magnitude
   logic [NUM_W-1:0] mag9_ff [LANES];
   logic [LANES-1:0] neg9_ff;
   logic [DEN_W-1:0] j9_ff;
   logic             bad9_ff;
   logic [PW-1:0]    pr_abs  [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         pr_abs[k] = (pr8_ff[k] < 0) ? PW'(-pr8_ff[k]) : PW'(pr8_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         for (int k = 0; k < LANES; k++) begin
            mag9_ff[k] <= NUM_W'(pr_abs[k]) << NUM_SHIFT;
            neg9_ff[k] <= pr8_ff[k] < 0;
         end
         // Only meaningful when the volume is positive, where it fits DEN_W bits.
         j9_ff   <= j8_ff[DEN_W-1:0];
         bad9_ff <= bad8_ff;
      end
   end

   // ------------------------------------------------------- divider lanes
   div_res_type div_res [LANES];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      acs_div u_div (
         .clock  (clock),
         .en     (en[ST_DIV0 +: DIV_ST]),
         .num_in (mag9_ff[k]),
         .den_in (j9_ff),
         .res    (div_res[k])
      );
   end

   // Sign and volume flag travel beside the divider.
   logic [LANES-1:0] neg_d_ff [DIV_ST];
   logic             bad_d_ff [DIV_ST];

   always_ff @(posedge clock) begin
      if (en[ST_DIV0]) begin
         neg_d_ff[0] <= neg9_ff;
         bad_d_ff[0] <= bad9_ff;
      end
      for (int s = 1; s < DIV_ST; s++) begin
         if (en[ST_DIV0 + s]) begin
            neg_d_ff[s] <= neg_d_ff[s-1];
            bad_d_ff[s] <= bad_d_ff[s-1];
         end
      end
   end

   // ------------------------------------------- output stage: saturation
   logic [STRESS_W-1:0] stress_ff [LANES];
   logic                bad_ff;
   logic [STRESS_W-1:0] stress_in [LANES];
   logic [QUOT_W-1:0]   sat_lim   [LANES];
   logic                neg_out;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         neg_out    = neg_d_ff[DIV_ST-1][k];
         // A negative result may reach one step further than a positive one.
         sat_lim[k] = neg_out ? STRESS_MIN : STRESS_MAX;
         if (bad_d_ff[DIV_ST-1]) begin
            stress_in[k] = '0;
         end else if (div_res[k].ovf || (div_res[k].quot > sat_lim[k])) begin
            stress_in[k] = sat_lim[k];
         end else if (neg_out) begin
            stress_in[k] = STRESS_W'(-div_res[k].quot);
         end else begin
            stress_in[k] = STRESS_W'(div_res[k].quot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[ST_OUT]) begin
         for (int k = 0; k < LANES; k++) begin
            stress_ff[k] <= stress_in[k];
         end
         bad_ff <= bad_d_ff[DIV_ST-1];
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rsp_tdata[k*STRESS_W +: STRESS_W] = stress_ff[k];
      end
   end

   assign rsp_tuser = bad_ff;

endmodule

// File: hw/rtl/acs_checker.sv
// ----------------------------------------------------------------------------
// acs_checker
// Port-level checks on the active contraction stress block, bound to its top.
// ----------------------------------------------------------------------------
module acs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [acs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);
   import acs_pkg::*;

   // Nothing is offered straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // A ready consumer keeps the whole pipeline moving.
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("input stalled while output drains");

   // A non-positive volume gives zero stress.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("stress not zero on bad volume");

   // Following a low request valid, the input ready is a defined level.
   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      !req_tvalid |=> !$isunknown(req_tready))
      else $error("input ready undefined");

endmodule

bind active_contraction_stress acs_checker u_acs_checker (.*);

// File: tb/acs_stress_checker.sv
// ----------------------------------------------------------------------------
// acs_stress_checker
// Watches the request, response and register ports of the active contraction
// stress block, predicts each stress result and compares it field by field.
// ----------------------------------------------------------------------------
module acs_stress_checker
   import acs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_wr_en,
   input  logic [TENS_W-1:0]      csr_wr_data,
   output int                     fail_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [159:0] wide_type;

   typedef struct {
      logic [STRESS_W-1:0] stress [LANES];
      logic                bad_volume;
   } stress_point_type;

   localparam wide_type HALF_LSB = wide_type'(1) <<< 47;
   localparam wide_type POS_LIM  = wide_type'(64'sd2147483647);
   localparam wide_type NEG_LIM  = -wide_type'(64'sd2147483648);

   stress_point_type    stress_due [$];
   logic signed [31:0]  tension;
   int                  fails;

   function automatic string lane_name(int k);
      case (k)
         0: return "stress_xx";
         1: return "stress_yy";
         2: return "stress_zz";
         3: return "stress_xy";
         4: return "stress_yz";
         default: return "stress_xz";
      endcase
   endfunction

   function automatic stress_point_type predict_stress(logic [REQ_DATA_W-1:0] d,
                                                       logic signed [31:0] t0);
      wide_type f [3][3];
      wide_type n [3];
      wide_type nt [3];
      wide_type c0, c1, c2, jac, b, dy, num, q;
      stress_point_type r;
      int ri, ci;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            f[i][j] = $signed(d[(i*3+j)*GRAD_W +: GRAD_W]);
         end
         n[i] = $signed(d[FIB_BASE + i*FIB_W +: FIB_W]);
      end
      c0  = f[1][1]*f[2][2] - f[1][2]*f[2][1];
      c1  = f[1][0]*f[2][2] - f[1][2]*f[2][0];
      c2  = f[1][0]*f[2][1] - f[1][1]*f[2][0];
      jac = c0*f[0][0] - c1*f[0][1] + c2*f[0][2];
      r.bad_volume = (jac <= 0);
      for (int i = 0; i < 3; i++) begin
         nt[i] = f[i][0]*n[0] + f[i][1]*n[1] + f[i][2]*n[2];
      end
      for (int k = 0; k < LANES; k++) begin
         ri = ROW_IDX[k];
         ci = COL_IDX[k];
         if (r.bad_volume) begin
            r.stress[k] = '0;
         end else begin
            b   = f[ri][0]*f[ci][0] + f[ri][1]*f[ci][1] + f[ri][2]*f[ci][2];
            dy  = (nt[ri]*nt[ci] + HALF_LSB) >>> ROUND_SHIFT;
            num = ((b - dy) * wide_type'(t0)) <<< NUM_SHIFT;
            q   = num / jac;   // truncates toward zero
            if (q > POS_LIM) r.stress[k] = STRESS_MAX;
            else if (q < NEG_LIM) r.stress[k] = STRESS_MIN;
            else r.stress[k] = q[STRESS_W-1:0];
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      stress_point_type e;
      if (reset) begin
         tension = '0;
         stress_due.delete();
         fails = 0;
      end else begin
         // Outputs are compared before the request of this edge is queued.
         if (rsp_tvalid && rsp_tready) begin
            if (stress_due.size() == 0) begin
               $error("stress result with no input outstanding");
               fails++;
            end else begin
               e = stress_due.pop_front();
               for (int k = 0; k < LANES; k++) begin
                  if (rsp_tdata[k*STRESS_W +: STRESS_W] !== e.stress[k]) begin
                     $error("%s: expected %h, got %h", lane_name(k), e.stress[k],
                            rsp_tdata[k*STRESS_W +: STRESS_W]);
                     fails++;
                  end
               end
               if (rsp_tuser !== e.bad_volume) begin
                  $error("bad_volume: expected %b, got %b", e.bad_volume, rsp_tuser);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            stress_due.push_back(predict_stress(req_tdata, tension));
         end
         if (csr_wr_en) begin
            tension = csr_wr_data;
         end
      end
      pending    <= stress_due.size();
      fail_count <= fails;
   end

   initial begin
      pending    = 0;
      fail_count = 0;
      fails      = 0;
      tension    = '0;
   end

   final begin
      if (stress_due.size() != 0) begin
         $error("%0d stress results never arrived", stress_due.size());
      end
   end
endmodule

// File: tb/tb_active_contraction_stress.sv
// ----------------------------------------------------------------------------
// tb_active_contraction_stress
// Drives material points through the stress block in random bursts under
// several active tensions while the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_active_contraction_stress;
   import acs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int DRAIN_WAIT = 60;
   localparam int RANDOM_PER_SETTING = 300;
   localparam logic [31:0] ONE_Q824 = 32'h0100_0000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_wr_en = 1'b0;
   logic [TENS_W-1:0]     csr_wr_data = '0;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int ready_mode = 0;
   int ready_left = 0;
   int burst_left = 0;

   // Tensions visited in turn: unit, the two extremes, zero, a negative and a
   // random one.
   logic [31:0] tension_plan [6] = '{32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h0000_0000, 32'hFFFC_8000, 32'h0000_0000};

   active_contraction_stress dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   acs_stress_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver switches between always ready, a coin toss and long stalls,
   // holding each mode for a random number of cycles.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         ready_left = $urandom_range(8, 200);
      end
      ready_left--;
      case (ready_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= $urandom_range(0, 1);
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 5) == 0);
         end
      endcase
   end

   // Watchdog: any accepted transaction on either side restarts the count.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [REQ_DATA_W-1:0] pack_point(logic [31:0] g [9],
                                                        logic [25:0] n [3]);
      logic [REQ_DATA_W-1:0] d;
      d = '0;
      for (int k = 0; k < 9; k++) d[k*GRAD_W +: GRAD_W] = g[k];
      for (int k = 0; k < 3; k++) d[FIB_BASE + k*FIB_W +: FIB_W] = n[k];
      return d;
   endfunction

   // Sends one transaction. Within a burst tvalid stays high; when the burst
   // runs out it drops for a random gap, sometimes none at all.
   task automatic send_point(logic [REQ_DATA_W-1:0] d);
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock iff req_tready);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_diag(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [25:0] nx, logic [25:0] ny, logic [25:0] nz);
      logic [31:0] g [9];
      logic [25:0] n [3];
      g = '{a, 0, 0, 0, b, 0, 0, 0, c};
      n = '{nx, ny, nz};
      send_point(pack_point(g, n));
   endtask

   task automatic send_uniform(logic [31:0] v, logic [25:0] nv);
      logic [31:0] g [9];
      logic [25:0] n [3];
      g = '{v, v, v, v, v, v, v, v, v};
      n = '{nv, nv, nv};
      send_point(pack_point(g, n));
   endtask

   // Writes the tension only once the block has emptied and settled.
   task automatic write_tension(logic [31:0] v);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [25:0] rand_fiber();
      return 26'($signed($urandom_range(0, 33554432)) - 32'sd16777216);
   endfunction

   // Mostly points near the identity, as a mesh would give; the rest are
   // fully random gradients, some with a singular or inverted volume.
   task automatic send_random_point();
      logic [31:0] g [9];
      logic [25:0] n [3];
      int kind;
      kind = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) n[k] = rand_fiber();
      for (int k = 0; k < 9; k++) begin
         if (kind < 6) begin
            g[k] = $signed($urandom_range(0, 1 << 23)) - 32'sd4194304;
            if (k % 4 == 0) g[k] += ONE_Q824;
         end else begin
            g[k] = $urandom();
         end
      end
      if (kind == 9) begin
         // Copy a row so that the volume is exactly zero.
         g[6] = g[0];
         g[7] = g[1];
         g[8] = g[2];
      end
      send_point(pack_point(g, n));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under the reset tension of zero, then under unit tension.
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) write_tension(32'h0001_0000);
         send_diag(ONE_Q824, ONE_Q824, ONE_Q824, 26'h100_0000, 26'h0, 26'h0);
         send_diag(ONE_Q824, ONE_Q824, ONE_Q824, 26'h0, 26'h0, 26'h300_0000);
         send_diag(32'h0200_0000, ONE_Q824, 32'h0080_0000, 26'h0, 26'h100_0000, 26'h0);
         // Non-unit fibre, used as given.
         send_diag(ONE_Q824, ONE_Q824, ONE_Q824, 26'h0_8000, 26'h0_4000, 26'h0);
         // Zero and negative volume.
         send_diag(32'h0, ONE_Q824, ONE_Q824, 26'h100_0000, 26'h0, 26'h0);
         send_diag(32'hFF00_0000, ONE_Q824, ONE_Q824, 26'h100_0000, 26'h0, 26'h0);
         send_diag(32'hFF00_0000, 32'hFF00_0000, 32'hFF00_0000, 26'h0, 26'h0, 26'h0);
         // Tiny volume drives the stress into saturation when the tension is not zero.
         send_diag(ONE_Q824, ONE_Q824, 32'h1, 26'h0, 26'h0, 26'h0);
         send_diag(32'h7FFF_FFFF, 32'h1, 32'h1, 26'h100_0000, 26'h100_0000, 26'h0);
         send_diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   26'h100_0000, 26'h300_0000, 26'h100_0000);
         send_diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   26'h300_0000, 26'h300_0000, 26'h300_0000);
         send_diag(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   26'h3FF_FFFF, 26'h0, 26'h1);
         send_uniform(32'h7FFF_FFFF, 26'h100_0000);
         send_uniform(32'hFFFF_FFFF, 26'h3FF_FFFF);
      end

      for (int s = 0; s < 6; s++) begin
         if (s == 5) tension_plan[s] = $urandom();
         write_tension(tension_plan[s]);
         for (int i = 0; i < RANDOM_PER_SETTING; i++) send_random_point();
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count != 0) begin
         $display("end of test: mismatches");
      end else begin
         $display("end of test: clean");
      end
      $finish;
   end
endmodule
